/* hw/rtl/hann_smoothing_filter_core_assert.svh */
// Assertion macros for the smoothing filter RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef HANN_SMOOTHING_FILTER_CORE_ASSERT_SVH
`define HANN_SMOOTHING_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define HSF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsf assertion failed");

// next-cycle implication
`define HSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsf assertion failed");

`endif

/* hw/rtl/hsf_pkg.sv */
// Package for the Hann smoothing filter: widths, item types, control structs,
// rotation and reciprocal constants. No dependencies.
`default_nettype none

package hsf_pkg;

  localparam int WINDOW   = 31;
  localparam int WP_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SMP_W    = 16;
  localparam int ACCS_W   = 40;
  localparam int WSUM_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int DIFF_W   = ACCS_W + 1;
  localparam int MUL_A_W  = 25;
  localparam int MUL_B_W  = 32;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 72;
  localparam int ROT_FRAC = 30;
  localparam int OUT_FRAC = 39;
  localparam int Y_W      = ACC_W - OUT_FRAC;
  localparam int STEP_W   = 4;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [63:0] THETA      = TWO_PI_Q60 / 64'(WINDOW + 1);
  localparam int          TAYLOR_N   = 40;

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  function automatic logic [63:0] taylor(logic want_sin);
    logic [63:0] term;
    logic [63:0] cs;
    logic [63:0] sn;
    term = ONE_Q60;
    cs   = ONE_Q60;
    sn   = '0;
    for (int n = 1; n <= TAYLOR_N; n++) begin
      term = mul_q60(term / 64'(n), THETA);
      unique case (n % 4)
        1: sn = sn + term;
        2: cs = cs - term;
        3: sn = sn - term;
        default: cs = cs + term;
      endcase
    end
    return want_sin ? sn : cs;
  endfunction

  function automatic logic signed [MUL_B_W-1:0] round_q30(logic [63:0] x);
    logic signed [63:0] t;
    t = $signed(x) + 64'sd536870912;
    return MUL_B_W'(t >>> 30);
  endfunction

  localparam logic signed [MUL_B_W-1:0] COEF_C  = round_q30(taylor(1'b0));
  localparam logic signed [MUL_B_W-1:0] COEF_S  = round_q30(taylor(1'b1));
  localparam logic signed [MUL_B_W-1:0] COEF_NS = -COEF_S;
  localparam int RECIP_I = ((1 << 23) + (WINDOW + 1) / 2) / (WINDOW + 1);
  localparam logic signed [MUL_B_W-1:0] RECIP = MUL_B_W'(RECIP_I);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] smoothed;
    logic                    block_end;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROT,
    S_WAIT_NC,
    S_OUT,
    S_WAIT_Y,
    S_PUSH
  } state_t;

  // partial products in issue order; the step counter walks this list
  typedef enum logic [STEP_W-1:0] {
    OP_SH_CC,
    OP_SL_CC,
    OP_CH_SS,
    OP_CL_SS,
    OP_CH_CC,
    OP_CL_CC,
    OP_SH_NSS,
    OP_SL_NSS,
    OP_DH_RC,
    OP_DL_RC
  } op_t;

  typedef struct packed {
    logic in_ready;
    logic mac_issue;
    op_t  op;
    logic ram_we;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic                      valid;
    op_t                       op;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic done;
    op_t  op;
  } mac_res_t;

  function automatic logic op_shift(op_t op);
    unique case (op)
      OP_SH_CC, OP_CH_SS, OP_CH_CC, OP_SH_NSS, OP_DH_RC: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_first(op_t op);
    unique case (op)
      OP_SH_CC, OP_CH_CC, OP_DH_RC: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_last(op_t op);
    unique case (op)
      OP_CL_SS, OP_SL_NSS, OP_DL_RC: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic signed [ACC_W-1:0] op_bias(op_t op);
    unique case (op)
      OP_DH_RC: return ACC_W'(1) <<< (OUT_FRAC - 1);
      default:  return ACC_W'(1) <<< (ROT_FRAC - 1);
    endcase
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hsf_ram.sv */
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
`default_nettype none

module hsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hsf_mac.sv */
// Shared multiply-accumulate unit: registered 25x32 product, then accumulate.
// Depends on hsf_pkg.
`default_nettype none

module hsf_mac (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire hsf_pkg::mac_req_t               req,
  output hsf_pkg::mac_res_t                    res,
  output logic signed [hsf_pkg::ACC_W-1:0]     acc
);

  logic                                  p_valid_r;
  hsf_pkg::op_t                          p_op_r;
  logic signed [hsf_pkg::PROD_W-1:0]     prod_r;
  logic signed [hsf_pkg::PROD_W-1:0]     prod_nxt;
  logic signed [hsf_pkg::ACC_W-1:0]      acc_r;
  logic signed [hsf_pkg::ACC_W-1:0]      acc_nxt;
  logic signed [hsf_pkg::ACC_W-1:0]      addend;
  logic signed [hsf_pkg::ACC_W-1:0]      base;
  logic                                  done_r;
  hsf_pkg::op_t                          done_op_r;

  assign prod_nxt = $signed(req.a) * $signed(req.b);

  always_comb begin
    if (hsf_pkg::op_shift(p_op_r)) begin
      addend = $signed({prod_r[hsf_pkg::ACC_W-hsf_pkg::FRAC_W-1:0],
                        {hsf_pkg::FRAC_W{1'b0}}});
    end else begin
      addend = $signed({{(hsf_pkg::ACC_W-hsf_pkg::PROD_W){prod_r[hsf_pkg::PROD_W-1]}},
                        prod_r});
    end
    base    = hsf_pkg::op_first(p_op_r) ? hsf_pkg::op_bias(p_op_r) : acc_r;
    acc_nxt = base + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      p_valid_r <= req.valid;
      done_r    <= p_valid_r && hsf_pkg::op_last(p_op_r);
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      prod_r <= prod_nxt;
      p_op_r <= req.op;
    end
    if (p_valid_r) begin
      acc_r     <= acc_nxt;
      done_op_r <= p_op_r;
    end
  end

  assign res.done = done_r;
  assign res.op   = done_op_r;
  assign acc      = acc_r;

endmodule

`default_nettype wire

/* hw/rtl/hsf_seq.sv */
// Sequencer: steps the multiply-accumulate unit through one item's products.
// Depends on hsf_pkg and hann_smoothing_filter_core_assert.svh.
`default_nettype none
`include "hann_smoothing_filter_core_assert.svh"

module hsf_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_free,
  input  wire hsf_pkg::mac_res_t mac_res,
  output hsf_pkg::ctl_t          ctl
);

  hsf_pkg::state_t             state_r;
  hsf_pkg::state_t             state_nxt;
  logic [hsf_pkg::STEP_W-1:0]  step_r;
  logic [hsf_pkg::STEP_W-1:0]  step_nxt;
  hsf_pkg::op_t                op_cur;

  assign op_cur = hsf_pkg::op_t'(step_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      hsf_pkg::S_IDLE: begin
        step_nxt = hsf_pkg::STEP_W'(hsf_pkg::OP_SH_CC);
        if (in_valid) begin
          state_nxt = hsf_pkg::S_ROT;
        end
      end
      hsf_pkg::S_ROT: begin
        step_nxt = step_r + hsf_pkg::STEP_W'(1);
        if (op_cur == hsf_pkg::OP_SL_NSS) begin
          state_nxt = hsf_pkg::S_WAIT_NC;
        end
      end
      hsf_pkg::S_WAIT_NC: begin
        if (mac_res.done && mac_res.op == hsf_pkg::OP_SL_NSS) begin
          state_nxt = hsf_pkg::S_OUT;
        end
      end
      hsf_pkg::S_OUT: begin
        step_nxt = step_r + hsf_pkg::STEP_W'(1);
        if (op_cur == hsf_pkg::OP_DL_RC) begin
          state_nxt = hsf_pkg::S_WAIT_Y;
        end
      end
      hsf_pkg::S_WAIT_Y: begin
        if (mac_res.done && mac_res.op == hsf_pkg::OP_DL_RC) begin
          state_nxt = hsf_pkg::S_PUSH;
        end
      end
      hsf_pkg::S_PUSH: begin
        if (out_free) begin
          state_nxt = hsf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hsf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.in_ready  = 1'b0;
    ctl.mac_issue = 1'b0;
    ctl.op        = op_cur;
    ctl.ram_we    = 1'b0;
    ctl.out_load  = 1'b0;
    unique case (state_r)
      hsf_pkg::S_IDLE:    ctl.in_ready = 1'b1;
      hsf_pkg::S_ROT: begin
        ctl.mac_issue = 1'b1;
        ctl.ram_we    = (op_cur == hsf_pkg::OP_SH_CC);
      end
      hsf_pkg::S_OUT:     ctl.mac_issue = 1'b1;
      hsf_pkg::S_PUSH:    ctl.out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsf_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  `HSF_ASSERT_IMPLY(a_nc_in_wait, clk, rst_n,
    mac_res.done && mac_res.op == hsf_pkg::OP_SL_NSS, state_r == hsf_pkg::S_WAIT_NC)
  `HSF_ASSERT_IMPLY(a_y_in_wait, clk, rst_n,
    mac_res.done && mac_res.op == hsf_pkg::OP_DL_RC, state_r == hsf_pkg::S_WAIT_Y)
  `HSF_ASSERT_IMPLY(a_out_steps, clk, rst_n, state_r == hsf_pkg::S_OUT,
    op_cur == hsf_pkg::OP_DH_RC || op_cur == hsf_pkg::OP_DL_RC)
  `HSF_ASSERT_NEXT(a_no_done_idle, clk, rst_n, state_r == hsf_pkg::S_IDLE,
    !(mac_res.done && state_r == hsf_pkg::S_ROT && step_r == '0))

endmodule

`default_nettype wire

/* hw/rtl/hann_smoothing_filter_core.sv */
// Channel  Ports                          Payload
// in       in_valid / in_ready / in_item  sample (s16), block_last
// out      out_valid / out_ready / out_item  smoothed (s16), block_end
//
// One item at a time: its result is in the output register before the next
// accept. The single 25x32 multiply-accumulate unit takes ten partial
// products in turn (eight for the rotation, two for the reciprocal scale).
// rst_n (synchronous) clears accumulators, pointer and fill flag; the delay
// line RAM reads as zero until the pointer first wraps, so no clearing pass.
// The output register lets a new item be taken while a result waits; a
// finished result holds in the core until the register frees.
// Depends on hsf_pkg, hsf_ram, hsf_mac, hsf_seq.
`default_nettype none

module hann_smoothing_filter_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hsf_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hsf_pkg::out_item_t      out_item
);

  hsf_pkg::ctl_t                         ctl;
  hsf_pkg::mac_req_t                     mac_req;
  hsf_pkg::mac_res_t                     mac_res;
  logic signed [hsf_pkg::ACC_W-1:0]      mac_acc;

  logic [hsf_pkg::WP_W-1:0]              wp_r;
  logic [hsf_pkg::WP_W-1:0]              wp_nxt;
  logic                                  full_r;
  logic [hsf_pkg::WP_W-1:0]              wa_r;
  logic                                  old_ok_r;
  logic signed [hsf_pkg::SMP_W-1:0]      s_r;
  logic                                  last_r;
  logic signed [hsf_pkg::ACCS_W-1:0]     sin_r;
  logic signed [hsf_pkg::ACCS_W-1:0]     cos_r;
  logic signed [hsf_pkg::ACCS_W-1:0]     ns_r;
  logic signed [hsf_pkg::WSUM_W-1:0]     wsum_r;
  logic                                  out_valid_r;
  hsf_pkg::out_item_t                    out_r;

  logic                                  in_fire;
  logic                                  out_free;
  logic [hsf_pkg::SMP_W-1:0]             ram_rdata;
  logic signed [hsf_pkg::SMP_W-1:0]      old;
  logic signed [hsf_pkg::ACCS_W-1:0]     cos_add;
  logic signed [hsf_pkg::ACCS_W-1:0]     rot_res;
  logic signed [hsf_pkg::ACCS_W-1:0]     cos_upd;
  logic signed [hsf_pkg::WSUM_W-1:0]     wsum_upd;
  logic signed [hsf_pkg::DIFF_W-1:0]     diff;
  logic signed [hsf_pkg::Y_W-1:0]        y_full;
  logic signed [hsf_pkg::SMP_W-1:0]      y_sat;
  logic signed [hsf_pkg::MUL_A_W-1:0]    sin_hi;
  logic signed [hsf_pkg::MUL_A_W-1:0]    sin_lo;
  logic signed [hsf_pkg::MUL_A_W-1:0]    cos_hi;
  logic signed [hsf_pkg::MUL_A_W-1:0]    cos_lo;
  logic signed [hsf_pkg::MUL_A_W-1:0]    diff_hi;
  logic signed [hsf_pkg::MUL_A_W-1:0]    diff_lo;

  localparam int PAD_W = hsf_pkg::MUL_A_W - hsf_pkg::FRAC_W;

  assign in_fire   = in_valid && ctl.in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = ctl.in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  hsf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .mac_res  (mac_res),
    .ctl      (ctl)
  );

  hsf_ram #(
    .WIDTH (hsf_pkg::SMP_W),
    .DEPTH (hsf_pkg::WINDOW)
  ) u_dline (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (wa_r),
    .wdata (s_r),
    .re    (in_fire),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

  hsf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .res   (mac_res),
    .acc   (mac_acc)
  );

  always_comb begin
    old      = old_ok_r ? $signed(ram_rdata) : '0;
    wp_nxt   = (wp_r == hsf_pkg::WP_W'(hsf_pkg::WINDOW - 1)) ? '0
                                                               : wp_r + hsf_pkg::WP_W'(1);
    cos_add  = cos_r + $signed({{(hsf_pkg::ACCS_W-hsf_pkg::SMP_W-hsf_pkg::FRAC_W)
                                 {in_item.sample[hsf_pkg::SMP_W-1]}},
                                in_item.sample, {hsf_pkg::FRAC_W{1'b0}}});
    rot_res  = mac_acc[hsf_pkg::ROT_FRAC+hsf_pkg::ACCS_W-1:hsf_pkg::ROT_FRAC];
    cos_upd  = rot_res - $signed({{(hsf_pkg::ACCS_W-hsf_pkg::SMP_W-hsf_pkg::FRAC_W)
                                   {old[hsf_pkg::SMP_W-1]}},
                                  old, {hsf_pkg::FRAC_W{1'b0}}});
    wsum_upd = wsum_r
             + $signed({{(hsf_pkg::WSUM_W-hsf_pkg::SMP_W){s_r[hsf_pkg::SMP_W-1]}}, s_r})
             - $signed({{(hsf_pkg::WSUM_W-hsf_pkg::SMP_W){old[hsf_pkg::SMP_W-1]}}, old});
    diff     = $signed({wsum_r[hsf_pkg::WSUM_W-1], wsum_r, {hsf_pkg::FRAC_W{1'b0}}})
             - $signed({cos_r[hsf_pkg::ACCS_W-1], cos_r});
    y_full   = mac_acc[hsf_pkg::ACC_W-1:hsf_pkg::OUT_FRAC];
    if (y_full > $signed(hsf_pkg::Y_W'(hsf_pkg::SMP_MAX))) begin
      y_sat = hsf_pkg::SMP_MAX;
    end else if (y_full < hsf_pkg::Y_W'(hsf_pkg::SMP_MIN)) begin
      y_sat = hsf_pkg::SMP_MIN;
    end else begin
      y_sat = y_full[hsf_pkg::SMP_W-1:0];
    end
  end

  always_comb begin
    sin_hi  = $signed({sin_r[hsf_pkg::ACCS_W-1], sin_r[hsf_pkg::ACCS_W-1:hsf_pkg::FRAC_W]});
    sin_lo  = $signed({{PAD_W{1'b0}}, sin_r[hsf_pkg::FRAC_W-1:0]});
    cos_hi  = $signed({cos_r[hsf_pkg::ACCS_W-1], cos_r[hsf_pkg::ACCS_W-1:hsf_pkg::FRAC_W]});
    cos_lo  = $signed({{PAD_W{1'b0}}, cos_r[hsf_pkg::FRAC_W-1:0]});
    diff_hi = diff[hsf_pkg::DIFF_W-1:hsf_pkg::FRAC_W];
    diff_lo = $signed({{PAD_W{1'b0}}, diff[hsf_pkg::FRAC_W-1:0]});
    mac_req.valid = ctl.mac_issue;
    mac_req.op    = ctl.op;
    unique case (ctl.op)
      hsf_pkg::OP_SH_CC:  begin mac_req.a = sin_hi;  mac_req.b = hsf_pkg::COEF_C;  end
      hsf_pkg::OP_SL_CC:  begin mac_req.a = sin_lo;  mac_req.b = hsf_pkg::COEF_C;  end
      hsf_pkg::OP_CH_SS:  begin mac_req.a = cos_hi;  mac_req.b = hsf_pkg::COEF_S;  end
      hsf_pkg::OP_CL_SS:  begin mac_req.a = cos_lo;  mac_req.b = hsf_pkg::COEF_S;  end
      hsf_pkg::OP_CH_CC:  begin mac_req.a = cos_hi;  mac_req.b = hsf_pkg::COEF_C;  end
      hsf_pkg::OP_CL_CC:  begin mac_req.a = cos_lo;  mac_req.b = hsf_pkg::COEF_C;  end
      hsf_pkg::OP_SH_NSS: begin mac_req.a = sin_hi;  mac_req.b = hsf_pkg::COEF_NS; end
      hsf_pkg::OP_SL_NSS: begin mac_req.a = sin_lo;  mac_req.b = hsf_pkg::COEF_NS; end
      hsf_pkg::OP_DH_RC:  begin mac_req.a = diff_hi; mac_req.b = hsf_pkg::RECIP;   end
      hsf_pkg::OP_DL_RC:  begin mac_req.a = diff_lo; mac_req.b = hsf_pkg::RECIP;   end
      default:            begin mac_req.a = '0;      mac_req.b = '0;               end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      full_r      <= 1'b0;
      sin_r       <= '0;
      cos_r       <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        wp_r    <= wp_nxt;
        cos_r   <= cos_add;
        if (wp_nxt == '0) begin
          full_r <= 1'b1;
        end
      end
      if (mac_res.done && mac_res.op == hsf_pkg::OP_SL_NSS) begin
        sin_r  <= ns_r;
        cos_r  <= cos_upd;
        wsum_r <= wsum_upd;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_r      <= in_item.sample;
      last_r   <= in_item.block_last;
      wa_r     <= wp_r;
      old_ok_r <= full_r;
    end
    if (mac_res.done && mac_res.op == hsf_pkg::OP_CL_SS) begin
      ns_r <= rot_res;
    end
    if (ctl.out_load) begin
      out_r.smoothed  <= y_sat;
      out_r.block_end <= last_r;
    end
  end

endmodule

`default_nettype wire
